>>> rtl/core/pru_pkg.sv
// Shared types, constants and helper functions of the pixel ray unprojection block
package pru_pkg;

    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);
    localparam int CFG_IDX_W  = 4;
    localparam int COEF_W     = 32;
    localparam int PIX_W      = 16;
    localparam int PIX_FRAC   = 4;
    localparam int HOM_W      = 50;
    localparam int MAG_W      = HOM_W - 1;
    localparam int PT_W       = 32;
    localparam int PT_FRAC    = 16;
    localparam int PT_QW      = 32;
    localparam int DIFF_W     = PT_W + 1;
    localparam int UM_W       = 31;
    localparam int SUM_W      = 64;
    localparam int LEN_W      = SUM_W / 2;
    localparam int DIR_FRAC   = 30;
    localparam int DIR_QW     = 31;
    localparam int DIR_W      = 32;

    typedef logic [2*COEF_W-1:0] coef_pair_t;
    typedef logic signed [HOM_W-1:0] hom_t;

    // identity matrix
    localparam coef_pair_t COEF_RESET [NUM_PAIRS] = '{
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

    // sideband of the point dividers: lanes 0..2 near, 3..5 far
    typedef struct packed {
        logic       wzero;
        logic [5:0] neg;
        logic [5:0] ovf;
    } div_side_t;

    // sideband of the direction path
    typedef struct packed {
        logic                  degen;
        logic [2:0]            neg;
        logic [2:0][PT_W-1:0]  near;
    } dir_side_t;

    typedef struct packed {
        dir_side_t             base;
        logic [2:0][UM_W-1:0]  um;
    } sqrt_side_t;

    typedef struct packed {
        logic [2:0][PT_W-1:0]  origin;
        logic [2:0][DIR_W-1:0] dir;
        logic                  degen;
    } ray_t;

    // magnitude of a homogeneous component
    function automatic logic [MAG_W-1:0] hom_mag(hom_t h);
        hom_t n;
        n = -h;
        return h[HOM_W-1] ? n[MAG_W-1:0] : h[MAG_W-1:0];
    endfunction

    // signed Q16.16 point from quotient magnitude, saturated
    function automatic logic [PT_W-1:0] sat_point(logic [PT_QW-1:0] q, logic ovf,
                                                  logic neg);
        logic [PT_QW-1:0] qq;
        logic [PT_W-1:0]  res;
        qq = ovf ? '1 : q;
        if (neg) begin
            res = qq[PT_QW-1] ? {1'b1, {(PT_W-1){1'b0}}} : PT_W'(-qq);
        end else begin
            res = qq[PT_QW-1] ? {1'b0, {(PT_W-1){1'b1}}} : PT_W'(qq);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/pru_hom.sv
// Homogeneous products of the folded matrix for the near and far screen points
module pru_hom import pru_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] px,
    input  logic [PIX_W-1:0] py,
    input  coef_pair_t       coef [NUM_PAIRS],
    output logic             out_valid,
    output hom_t             h_near [4],
    output hom_t             h_far  [4]
);
    localparam int PROD_W = COEF_W + PIX_W + 1;

    logic signed [PROD_W-1:0] px_prod_reg [4];
    logic signed [PROD_W-1:0] py_prod_reg [4];
    logic signed [COEF_W-1:0] m2_reg [4];
    logic signed [COEF_W-1:0] m3_reg [4];
    logic                     v1_reg, v2_reg;
    hom_t                     base_h [4];
    hom_t                     off_h  [4];
    hom_t                     near_reg [4];
    hom_t                     far_reg  [4];

    // stage 1: column 0 and 1 products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                px_prod_reg[r] <= $signed(coef[2*r][2*COEF_W-1:COEF_W]) * $signed({1'b0, px});
                py_prod_reg[r] <= $signed(coef[2*r][COEF_W-1:0]) * $signed({1'b0, py});
                m2_reg[r]      <= $signed(coef[2*r+1][2*COEF_W-1:COEF_W]);
                m3_reg[r]      <= $signed(coef[2*r+1][COEF_W-1:0]);
            end
        end
    end

    // stage 2: z = -1 and z = +1 sums
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            base_h[r] = hom_t'(px_prod_reg[r]) + hom_t'(py_prod_reg[r])
                      + (hom_t'(m3_reg[r]) <<< PIX_FRAC);
            off_h[r]  = hom_t'(m2_reg[r]) <<< PIX_FRAC;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                near_reg[r] <= base_h[r] - off_h[r];
                far_reg[r]  <= base_h[r] + off_h[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign h_near    = near_reg;
    assign h_far     = far_reg;

endmodule

>>> rtl/core/pru_udiv.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
module pru_udiv #(
    parameter int LANES = 1,
    parameter int NW    = 8,
    parameter int DW    = 4,
    parameter int QW    = 4,
    parameter int SW    = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [LANES-1:0][NW-1:0] num,
    input  logic [LANES-1:0][DW-1:0] den,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    output logic [LANES-1:0][QW-1:0] quo,
    output logic [SW-1:0]            out_side
);
    logic                     v_reg    [1:QW];
    logic [SW-1:0]            side_reg [1:QW];
    logic [LANES-1:0][DW-1:0] rem_reg  [1:QW];
    logic [LANES-1:0][DW-1:0] den_reg  [1:QW];
    logic [LANES-1:0][QW-1:0] quo_reg  [1:QW];
    logic [LANES-1:0][QW-1:0] low_reg  [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                     v_in;
        logic [SW-1:0]            side_in;
        logic [LANES-1:0][DW-1:0] rem_in, den_in, rem_next;
        logic [LANES-1:0][QW-1:0] quo_in, low_in, quo_next, low_next;
        logic [LANES-1:0][DW:0]   trial;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = DW'(num[l][NW-1:QW]);
                    low_in[l] = num[l][QW-1:0];
                end
            end
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign den_in  = den;
            assign quo_in  = '0;
        end else begin : g_rest
            assign v_in    = v_reg[k];
            assign side_in = side_reg[k];
            assign rem_in  = rem_reg[k];
            assign den_in  = den_reg[k];
            assign quo_in  = quo_reg[k];
            assign low_in  = low_reg[k];
        end

        // bring down one numerator bit, subtract where it fits
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {rem_in[l], low_in[l][QW-1]};
                if (trial[l] >= {1'b0, den_in[l]}) begin
                    rem_next[l] = DW'(trial[l] - {1'b0, den_in[l]});
                    quo_next[l] = {quo_in[l][QW-2:0], 1'b1};
                end else begin
                    rem_next[l] = DW'(trial[l]);
                    quo_next[l] = {quo_in[l][QW-2:0], 1'b0};
                end
                low_next[l] = {low_in[l][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_in;
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_in;
                quo_reg[k+1]  <= quo_next;
                low_reg[k+1]  <= low_next;
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

>>> rtl/core/pru_norm.sv
// Pipelined left normaliser: shifts three magnitudes together until the largest tops out
module pru_norm #(
    parameter int W  = 31,
    parameter int SW = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2:0][W-1:0]   um_in,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [2:0][W-1:0]   um_out,
    output logic [SW-1:0]       out_side
);
    localparam int STG = $clog2(W);

    logic               v_reg    [1:STG];
    logic [SW-1:0]      side_reg [1:STG];
    logic [2:0][W-1:0]  um_reg   [1:STG];

    for (genvar k = 0; k < STG; k++) begin : g_shift
        localparam int SH = 1 << (STG - 1 - k);
        logic              v_in;
        logic [SW-1:0]     side_in;
        logic [2:0][W-1:0] um_src, um_next;
        logic [W-1:0]      any;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign um_src  = um_in;
        end else begin : g_rest
            assign v_in    = v_reg[k];
            assign side_in = side_reg[k];
            assign um_src  = um_reg[k];
        end

        // shift by SH when the top SH bits of all three are clear
        always_comb begin
            any = um_src[0] | um_src[1] | um_src[2];
            for (int j = 0; j < 3; j++) begin
                um_next[j] = (any[W-1 -: SH] == '0) ? (um_src[j] << SH) : um_src[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_in;
                um_reg[k+1]   <= um_next;
            end
        end
    end

    assign out_valid = v_reg[STG];
    assign um_out    = um_reg[STG];
    assign out_side  = side_reg[STG];

endmodule

>>> rtl/core/pru_isqrt.sv
// Pipelined integer square root, one result bit per stage
module pru_isqrt #(
    parameter int VW = 64,
    parameter int SW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [VW-1:0]     val,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [VW/2-1:0]   root,
    output logic [SW-1:0]     out_side
);
    localparam int STEPS = VW / 2;

    logic          v_reg    [1:STEPS];
    logic [SW-1:0] side_reg [1:STEPS];
    logic [VW-1:0] rad_reg  [1:STEPS];
    logic [VW-1:0] res_reg  [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
        logic          v_in;
        logic [SW-1:0] side_in;
        logic [VW-1:0] rad_in, res_in, rad_next, res_next;
        logic [VW:0]   trial;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rad_in  = val;
            assign res_in  = '0;
        end else begin : g_rest
            assign v_in    = v_reg[k];
            assign side_in = side_reg[k];
            assign rad_in  = rad_reg[k];
            assign res_in  = res_reg[k];
        end

        always_comb begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, rad_in} >= trial) begin
                rad_next = rad_in - trial[VW-1:0];
                res_next = (res_in >> 1) + BIT;
            end else begin
                rad_next = rad_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_in;
                rad_reg[k+1]  <= rad_next;
                res_reg[k+1]  <= res_next;
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign root      = res_reg[STEPS][VW/2-1:0];
    assign out_side  = side_reg[STEPS];

endmodule

>>> rtl/core/pixel_ray_unprojection.sv
// Throughput: one request per cycle; the 32-step point dividers, the 32-step square
// root and the 31-step direction dividers are fully pipelined, one bit per stage.
// Output register plus skid stage; the pipeline holds only while the skid stage is full.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity matrix.
// Configuration writes are taken every cycle (cfg_ready is always high).
module pixel_ray_unprojection import pru_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel_x,
    input  logic [PIX_W-1:0]      s_pixel_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_origin_x,
    output logic signed [31:0]    m_origin_y,
    output logic signed [31:0]    m_origin_z,
    output logic signed [31:0]    m_dir_x,
    output logic signed [31:0]    m_dir_y,
    output logic signed [31:0]    m_dir_z,
    output logic                  m_degenerate,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [2*COEF_W-1:0]   cfg_data
);
    logic        en;
    coef_pair_t  coef_reg [NUM_PAIRS];

    // coefficient registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PAIRS; i++) coef_reg[i] <= COEF_RESET[i];
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
            coef_reg[cfg_index[PAIR_IDX_W-1:0]] <= cfg_data;
        end
    end

    // homogeneous products
    logic hom_valid;
    hom_t h_near [4];
    hom_t h_far  [4];

    pru_hom u_hom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .px        (s_pixel_x),
        .py        (s_pixel_y),
        .coef      (coef_reg),
        .out_valid (hom_valid),
        .h_near    (h_near),
        .h_far     (h_far)
    );

    // magnitudes and signs for the six point divisions
    hom_t                       num_h [6];
    hom_t                       den_h [6];
    logic [5:0][MAG_W-1:0]      un_reg, ud_reg;
    logic [5:0]                 neg_reg;
    logic                       wz_reg, p1_valid_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num_h[j]   = h_near[j];
            num_h[j+3] = h_far[j];
            den_h[j]   = h_near[3];
            den_h[j+3] = h_far[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                un_reg[l]  <= hom_mag(num_h[l]);
                ud_reg[l]  <= hom_mag(den_h[l]);
                neg_reg[l] <= num_h[l][HOM_W-1] ^ den_h[l][HOM_W-1];
            end
            wz_reg <= (h_near[3] == '0) || (h_far[3] == '0);
        end
    end

    // point dividers
    logic [5:0][MAG_W+PT_FRAC-1:0] pdiv_num;
    div_side_t                     pdiv_side, pdiv_side_out;
    logic [5:0][PT_QW-1:0]         pdiv_quo;
    logic                          pdiv_valid;

    always_comb begin
        pdiv_side.wzero = wz_reg;
        pdiv_side.neg   = neg_reg;
        for (int l = 0; l < 6; l++) begin
            pdiv_num[l]      = {un_reg[l], {PT_FRAC{1'b0}}};
            // integer part at or above 2^16 saturates
            pdiv_side.ovf[l] = {{PT_FRAC{1'b0}}, un_reg[l]} >= {ud_reg[l], {PT_FRAC{1'b0}}};
        end
    end

    pru_udiv #(
        .LANES (6),
        .NW    (MAG_W + PT_FRAC),
        .DW    (MAG_W),
        .QW    (PT_QW),
        .SW    ($bits(div_side_t))
    ) u_pdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p1_valid_reg),
        .num       (pdiv_num),
        .den       (ud_reg),
        .in_side   (pdiv_side),
        .out_valid (pdiv_valid),
        .quo       (pdiv_quo),
        .out_side  (pdiv_side_out)
    );

    // saturate to Q16.16 points
    logic [2:0][PT_W-1:0] near_reg, far_reg;
    logic                 s1_degen_reg, s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                near_reg[j] <= sat_point(pdiv_quo[j], pdiv_side_out.ovf[j],
                                         pdiv_side_out.neg[j]);
                far_reg[j]  <= sat_point(pdiv_quo[j+3], pdiv_side_out.ovf[j+3],
                                         pdiv_side_out.neg[j+3]);
            end
            s1_degen_reg <= pdiv_side_out.wzero;
        end
    end

    // difference far - near, sign and magnitude
    logic [2:0][DIFF_W-1:0] diff, diff_neg;
    logic [2:0][PT_W-1:0]   um32_reg;
    dir_side_t              s2_side_reg;
    logic                   s2_valid_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            diff[j]     = {far_reg[j][PT_W-1], far_reg[j]} - {near_reg[j][PT_W-1], near_reg[j]};
            diff_neg[j] = -diff[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                um32_reg[j]       <= diff[j][DIFF_W-1] ? diff_neg[j][PT_W-1:0]
                                                       : diff[j][PT_W-1:0];
                s2_side_reg.neg[j] <= diff[j][DIFF_W-1];
            end
            s2_side_reg.near  <= near_reg;
            s2_side_reg.degen <= s1_degen_reg;
        end
    end

    // right shift when the largest magnitude has reached bit 31; zero length check
    logic                 rshift, zero_len;
    logic [2:0][UM_W-1:0] um31_reg;
    dir_side_t            s3_side_reg;
    logic                 s3_valid_reg;

    assign rshift   = um32_reg[0][PT_W-1] | um32_reg[1][PT_W-1] | um32_reg[2][PT_W-1];
    assign zero_len = (um32_reg[0] == '0) && (um32_reg[1] == '0) && (um32_reg[2] == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                um31_reg[j] <= rshift ? um32_reg[j][PT_W-1:1] : um32_reg[j][UM_W-1:0];
            end
            s3_side_reg.neg   <= s2_side_reg.neg;
            s3_side_reg.near  <= s2_side_reg.near;
            s3_side_reg.degen <= s2_side_reg.degen | zero_len;
        end
    end

    // left normalisation
    logic                 nm_valid;
    logic [2:0][UM_W-1:0] nm_um;
    dir_side_t            nm_side;

    pru_norm #(
        .W  (UM_W),
        .SW ($bits(dir_side_t))
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .um_in     (um31_reg),
        .in_side   (s3_side_reg),
        .out_valid (nm_valid),
        .um_out    (nm_um),
        .out_side  (nm_side)
    );

    // squares, then their sum
    logic [2:0][2*UM_W-1:0] sq_reg;
    sqrt_side_t             s4_side_reg, s5_side_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   s4_valid_reg, s5_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) sq_reg[j] <= nm_um[j] * nm_um[j];
            s4_side_reg.base <= nm_side;
            s4_side_reg.um   <= nm_um;
            sum_reg          <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            s5_side_reg      <= s4_side_reg;
        end
    end

    // length
    logic             sq_valid;
    logic [LEN_W-1:0] len;
    sqrt_side_t       sq_side;

    pru_isqrt #(
        .VW (SUM_W),
        .SW ($bits(sqrt_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .val       (sum_reg),
        .in_side   (s5_side_reg),
        .out_valid (sq_valid),
        .root      (len),
        .out_side  (sq_side)
    );

    // direction dividers: |d| * 2^30 / len
    logic [2:0][UM_W+DIR_FRAC-1:0] ddiv_num;
    logic [2:0][LEN_W-1:0]         ddiv_den;
    logic [2:0][DIR_QW-1:0]        ddiv_quo;
    dir_side_t                     ddiv_side;
    logic                          ddiv_valid;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ddiv_num[j] = {sq_side.um[j], {DIR_FRAC{1'b0}}};
            ddiv_den[j] = len;
        end
    end

    pru_udiv #(
        .LANES (3),
        .NW    (UM_W + DIR_FRAC),
        .DW    (LEN_W),
        .QW    (DIR_QW),
        .SW    ($bits(dir_side_t))
    ) u_ddiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (ddiv_num),
        .den       (ddiv_den),
        .in_side   (sq_side.base),
        .out_valid (ddiv_valid),
        .quo       (ddiv_quo),
        .out_side  (ddiv_side)
    );

    // final result: signs applied, degenerate results forced to zero
    ray_t ray_next, ray_reg;
    logic ray_valid_reg;

    always_comb begin
        ray_next.degen = ddiv_side.degen;
        for (int j = 0; j < 3; j++) begin
            ray_next.origin[j] = ddiv_side.degen ? '0 : ddiv_side.near[j];
            ray_next.dir[j]    = ddiv_side.degen ? '0 :
                                 ddiv_side.neg[j] ? -DIR_W'(ddiv_quo[j]) : DIR_W'(ddiv_quo[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) ray_reg <= ray_next;
    end

    // valid bits of the stages held in this module
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            ray_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= hom_valid;
            s1_valid_reg  <= pdiv_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= nm_valid;
            s5_valid_reg  <= s4_valid_reg;
            ray_valid_reg <= ddiv_valid;
        end
    end

    // output register with skid stage
    ray_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg, out_load, leave;

    assign en       = !skid_valid_reg;
    assign s_ready  = en;
    assign out_load = !out_valid_reg || m_ready;
    assign leave    = en && ray_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg  <= skid_valid_reg || leave;
            skid_valid_reg <= 1'b0;
        end else if (leave) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= skid_valid_reg ? skid_reg : ray_reg;
        end else if (leave) begin
            skid_reg <= ray_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_origin_x   = out_reg.origin[0];
    assign m_origin_y   = out_reg.origin[1];
    assign m_origin_z   = out_reg.origin[2];
    assign m_dir_x      = out_reg.dir[0];
    assign m_dir_y      = out_reg.dir[1];
    assign m_dir_z      = out_reg.dir[2];
    assign m_degenerate = out_reg.degen;

endmodule

>>> rtl/core/pru_checker.sv
// Port-level checks of the pixel ray unprojection block, bound to the top level
module pru_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_origin_x,
    input logic signed [31:0] m_origin_y,
    input logic signed [31:0] m_origin_z,
    input logic signed [31:0] m_dir_x,
    input logic signed [31:0] m_dir_y,
    input logic signed [31:0] m_dir_z,
    input logic               m_degenerate
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_origin_x) && $stable(m_dir_x)
                                && $stable(m_degenerate))
        else $error("result changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a degenerate ray carries zeros
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_origin_x == 0 && m_origin_y == 0 && m_origin_z == 0
                                    && m_dir_x == 0 && m_dir_y == 0 && m_dir_z == 0)
        else $error("degenerate ray with nonzero fields");

    // a proper ray has a nonzero direction
    a_dir_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> m_dir_x != 0 || m_dir_y != 0 || m_dir_z != 0)
        else $error("zero direction on a proper ray");

    // unit direction components stay within one
    a_dir_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |->
            m_dir_x <= 32'sh4000_0000 && m_dir_x >= -32'sh4000_0000 &&
            m_dir_y <= 32'sh4000_0000 && m_dir_y >= -32'sh4000_0000 &&
            m_dir_z <= 32'sh4000_0000 && m_dir_z >= -32'sh4000_0000)
        else $error("direction component above unit");

endmodule

bind pixel_ray_unprojection pru_checker u_pru_checker (.*);
